@@ sv/idq_pkg.sv @@
package idq_pkg;

  // Default storage shape.
  localparam int unsigned DepthDefault    = 256;
  localparam int unsigned WordBitsDefault = 32;

  // Fixed widths of the item fields.
  localparam int unsigned OpcodeW = 3;
  localparam int unsigned PosW    = 8;
  localparam int unsigned WordW   = 32;
  localparam int unsigned StatusW = 2;
  localparam int unsigned LengthW = 9;

  // Operation codes.
  typedef enum logic [OpcodeW-1:0] {
    OP_PUSH_BACK  = 3'd0,
    OP_PUSH_FRONT = 3'd1,
    OP_POP_BACK   = 3'd2,
    OP_POP_FRONT  = 3'd3,
    OP_GET        = 3'd4,
    OP_SET        = 3'd5,
    OP_CLEAR      = 3'd6
  } op_e;

  // Result status codes.
  typedef enum logic [StatusW-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2,
    ST_RANGE = 2'd3
  } status_e;

  // One input item.
  typedef struct packed {
    logic [OpcodeW-1:0] opcode;
    logic [PosW-1:0]    position;
    logic [WordW-1:0]   word_in;
  } in_item_t;

  // One result item.
  typedef struct packed {
    logic [WordW-1:0]   word_out;
    logic [StatusW-1:0] status;
    logic [LengthW-1:0] length_now;
  } out_item_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic exec;
    logic respond;
  } idq_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_free;
  } idq_stat_t;

endpackage

@@ sv/idq_ctrl.sv @@
module idq_ctrl import idq_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  idq_stat_t stat_i,
  output idq_cmd_t  cmd_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_RESP
  } state_e;

  state_e state_q, state_d;

  // Next state: take an item, run it on the store, then hand over the result.
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) state_d = S_EXEC;
      end
      S_EXEC: begin
        state_d = S_RESP;
      end
      S_RESP: begin
        if (stat_i.out_free) state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Commands decoded from the current state.
  assign in_stall_o    = (state_q != S_IDLE);
  assign cmd_o.load    = (state_q == S_IDLE) && in_valid_i;
  assign cmd_o.exec    = (state_q == S_EXEC);
  assign cmd_o.respond = (state_q == S_RESP) && stat_i.out_free;

endmodule

@@ sv/idq_dp.sv @@
module idq_dp import idq_pkg::*; #(
  parameter int unsigned DEPTH     = DepthDefault,
  parameter int unsigned WORD_BITS = WordBitsDefault
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  in_item_t  in_item_i,
  input  idq_cmd_t  cmd_i,
  output idq_stat_t stat_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_item_o
);

  localparam int unsigned AW   = $clog2(DEPTH);
  localparam int unsigned CW   = $clog2(DEPTH + 1);
  localparam int unsigned CMPW = (CW > PosW) ? CW : PosW;

  localparam logic [AW:0]   DepthSum  = (AW + 1)'(DEPTH);
  localparam logic [AW-1:0] DepthLast = AW'(DEPTH - 1);
  localparam logic [CW-1:0] DepthCnt  = CW'(DEPTH);

  // Item held while it runs.
  logic [OpcodeW-1:0] op_q;
  logic [PosW-1:0]    pos_q;
  logic [WordW-1:0]   word_q;

  // Ring state.
  logic [AW-1:0] head_q, head_d;
  logic [CW-1:0] count_q, count_d;

  // Storage ring and its registered read port.
  logic [WORD_BITS-1:0] mem_q [DEPTH];
  logic [WORD_BITS-1:0] rd_q;
  logic                 rd_ok_q;
  status_e              status_q;

  logic          wr_en, rd_en;
  logic [AW-1:0] offset, slot;
  logic [AW:0]   slot_sum;
  status_e       status_d;
  logic          full, empty, in_range;

  logic      out_valid_q, out_valid_d;
  out_item_t out_q;

  // Latch the accepted item.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q   <= in_item_i.opcode;
      pos_q  <= in_item_i.position;
      word_q <= in_item_i.word_in;
    end
  end

  assign full     = (count_q == DepthCnt);
  assign empty    = (count_q == '0);
  assign in_range = (CMPW'(pos_q) < CMPW'(count_q));

  // Ring slot of an offset from the head; the sum stays below twice the depth.
  assign slot_sum = {1'b0, head_q} + {1'b0, offset};
  always_comb begin
    if (slot_sum >= DepthSum) begin
      slot = AW'(slot_sum - DepthSum);
    end else begin
      slot = AW'(slot_sum);
    end
  end

  // Decode the operation into a store access and the new head and count.
  always_comb begin
    head_d   = head_q;
    count_d  = count_q;
    offset   = '0;
    wr_en    = 1'b0;
    rd_en    = 1'b0;
    status_d = ST_OK;
    case (op_e'(op_q))
      OP_PUSH_BACK: begin
        if (full) begin
          status_d = ST_FULL;
        end else begin
          offset  = AW'(count_q);
          wr_en   = 1'b1;
          count_d = count_q + 1'b1;
        end
      end
      OP_PUSH_FRONT: begin
        if (full) begin
          status_d = ST_FULL;
        end else begin
          offset  = DepthLast;
          wr_en   = 1'b1;
          head_d  = slot;
          count_d = count_q + 1'b1;
        end
      end
      OP_POP_BACK: begin
        if (empty) begin
          status_d = ST_EMPTY;
        end else begin
          count_d = count_q - 1'b1;
          offset  = AW'(count_q - 1'b1);
          rd_en   = 1'b1;
        end
      end
      OP_POP_FRONT: begin
        if (empty) begin
          status_d = ST_EMPTY;
        end else begin
          offset  = '0;
          rd_en   = 1'b1;
          head_d  = (head_q == DepthLast) ? '0 : head_q + 1'b1;
          count_d = count_q - 1'b1;
        end
      end
      OP_GET: begin
        if (!in_range) begin
          status_d = ST_RANGE;
        end else begin
          offset = AW'(pos_q);
          rd_en  = 1'b1;
        end
      end
      OP_SET: begin
        if (!in_range) begin
          status_d = ST_RANGE;
        end else begin
          offset = AW'(pos_q);
          wr_en  = 1'b1;
        end
      end
      OP_CLEAR: begin
        head_d  = '0;
        count_d = '0;
      end
      default: begin
      end
    endcase
  end

  // Head and count registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      count_q <= '0;
    end else if (cmd_i.exec) begin
      head_q  <= head_d;
      count_q <= count_d;
    end
  end

  // Store access: at most one write or one read per item.
  always_ff @(posedge clk_i) begin
    if (cmd_i.exec && wr_en) begin
      mem_q[slot] <= WORD_BITS'(word_q);
    end
    if (cmd_i.exec && rd_en) begin
      rd_q <= mem_q[slot];
    end
  end

  // Result flags of the running item.
  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      rd_ok_q  <= rd_en;
      status_q <= status_d;
    end
  end

  // Output register: holds a result until it is taken.
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_i.respond) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.respond) begin
      out_q.word_out   <= rd_ok_q ? WordW'(rd_q) : '0;
      out_q.status     <= status_q;
      out_q.length_now <= LengthW'(count_q);
    end
  end

  assign stat_o.out_free = !out_valid_q || !out_stall_i;
  assign out_valid_o     = out_valid_q;
  assign out_item_o      = out_q;

endmodule

@@ sv/indexed_double_ended_queue_core.sv @@
// Double-ended queue of up to DEPTH words with random access by index. Each
// item carries one operation (push or pop at either end, get or set at an
// index counted from the front, or clear) and yields exactly one result item
// with the word read or removed, a status code and the length afterwards.
// Words live in a single-port storage ring; front operations move the head
// slot rather than the data. From acceptance to a result ready at the output,
// an item is first registered, then makes at most one store access along
// with the head and count update, and then loads the output register. A
// new item is taken once the previous result is in the output register,
// so a stalled output holds up the input. The store needs no clearing
// after reset: only entries that were written are ever read.
module indexed_double_ended_queue_core import idq_pkg::*; #(
  parameter int unsigned DEPTH     = DepthDefault,
  parameter int unsigned WORD_BITS = WordBitsDefault
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_item_o
);

  idq_cmd_t  cmd;
  idq_stat_t stat;

  // Sequencer for one item at a time.
  idq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // Ring state, storage and output register.
  idq_dp #(
    .DEPTH     (DEPTH),
    .WORD_BITS (WORD_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_item_i   (in_item_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

endmodule
